// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by pnp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PNP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// Checked on every edge, reset included.
`define PNP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/pnp_pkg.sv =====
package pnp_pkg;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TICK   = 8'h60;
	localparam logic [7:0] CH_LO_X   = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_UP_N   = 8'h4E;

	localparam logic [63:0] ALL_ONES = '1;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_HELD  = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        held_zero;
		logic        decimal_mode;
		logic [63:0] accum;
		logic        bad;
		logic        ovf;
		logic        digit_seen;
	} parse_state_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
		logic        was_decimal;
	} parse_result_t;

	localparam parse_state_t STATE_CLEAR = '{
		phase: PH_START, held_zero: 1'b0, decimal_mode: 1'b0, accum: 64'd0,
		bad: 1'b0, ovf: 1'b0, digit_seen: 1'b0
	};

	// {valid, value}
	function automatic logic [4:0] digit_of(input logic [7:0] c, input logic dec);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]})
			r = {1'b1, c[3:0]};
		else if (!dec && (c inside {[8'h61:8'h66], [8'h41:8'h46]}))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	function automatic parse_state_t body_step(input parse_state_t s, input logic [7:0] c);
		parse_state_t r;
		logic [4:0]   dg;
		logic [67:0]  dec_sum;
		r  = s;
		dg = digit_of(c, s.decimal_mode);
		// accum * 10 + d as two shifts and two adds
		dec_sum = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0} + {64'd0, dg[3:0]};
		if (c != CH_TICK) begin
			if (!dg[4]) begin
				r.bad = 1'b1;
			end else begin
				r.digit_seen = 1'b1;
				if (!s.ovf) begin
					if (s.decimal_mode) begin
						if (dec_sum[67:64] != 4'd0)
							r.ovf = 1'b1;
						else
							r.accum = dec_sum[63:0];
					end else begin
						if (s.accum[63:60] != 4'd0)
							r.ovf = 1'b1;
						else
							r.accum = {s.accum[59:0], dg[3:0]};
					end
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/prefixed_number_text_parser.sv =====
// A tlast beat is registered at the input, then its result in the output register.
// Throughput: one character per cycle, but a final character waits while an untaken
// result is held; the per-character accumulate (x10 or x16 plus digit, with overflow
// check) is combinational on the parse state register. Reset (arst_n low,
// asynchronous): parse state cleared, width_mode = 0 (64-bit), no result pending.
module prefixed_number_text_parser import pnp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,       // width_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
	input  logic        s_axis_tlast,   // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] value
	output logic [1:0]  m_axis_tuser    // [0] ok, [1] was_decimal
);

	logic          width_mode_q;
	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res;
	logic          out_can_load;
	logic          adv;

	assign cfg_ready = 1'b1;

	// a non-final character never waits on the output side
	assign adv           = valid_s1 && (!last_s1 || out_can_load);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= 1'b0;
			valid_s1     <= 1'b0;
			state_q      <= STATE_CLEAR;
		end else begin
			if (cfg_valid)
				width_mode_q <= cfg_data;
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	pnp_char_step u_step (
		.cur        (state_q),
		.text_char  (char_s1),
		.last_char  (last_s1),
		.width_mode (width_mode_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	pnp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && last_s1),
		.res           (res),
		.can_load      (out_can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== hw/rtl/pnp_char_step.sv =====
module pnp_char_step import pnp_pkg::*; (
	input  parse_state_t  cur,
	input  logic [7:0]    text_char,
	input  logic          last_char,
	input  logic          width_mode,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic         is_x;
	logic         is_n;
	logic         do_body;
	parse_state_t base;
	parse_state_t upd;

	assign is_x = (text_char == CH_LO_X) || (text_char == CH_UP_X);
	assign is_n = (text_char == CH_LO_N) || (text_char == CH_UP_N);

	always_comb begin
		base    = cur;
		upd     = cur;
		do_body = 1'b0;
		case (cur.phase)
			PH_START: begin
				if (is_x || is_n) begin
					upd.decimal_mode = is_n;
					upd.phase        = PH_BODY;
				end else if (((text_char == CH_ZERO) || (text_char == CH_BSLASH))
						&& !last_char) begin
					upd.held_zero = (text_char == CH_ZERO);
					upd.phase     = PH_HELD;
				end else begin
					do_body = 1'b1;
				end
			end
			PH_HELD: begin
				upd.phase = PH_BODY;
				if (is_x || is_n) begin
					upd.decimal_mode = is_n;
				end else begin
					// held '0' is a zero digit on an empty accumulator, '\' is bad
					base.digit_seen = cur.digit_seen | cur.held_zero;
					base.bad        = cur.bad | ~cur.held_zero;
					do_body         = 1'b1;
				end
			end
			default: do_body = 1'b1;
		endcase
		base.phase = PH_BODY;
		if (do_body)
			upd = body_step(base, text_char);
	end

	always_comb begin
		res.ok          = !upd.bad && upd.digit_seen;
		res.value       = upd.accum;
		res.was_decimal = upd.decimal_mode;
		if (!width_mode) begin
			if (upd.ovf) begin
				if (upd.decimal_mode)
					res.ok = 1'b0;
				else
					res.value = ALL_ONES;
			end
		end else if (upd.ovf || (upd.accum[63:31] != 33'd0)) begin
			res.ok = 1'b0;
		end
		if (!res.ok)
			res.value = '0;
		nxt = last_char ? STATE_CLEAR : upd;
	end

endmodule

// ===== hw/rtl/pnp_out_reg.sv =====
module pnp_out_reg import pnp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  parse_result_t res,
	output logic          can_load,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,
	output logic [1:0]    m_axis_tuser
);

	logic          valid_q;
	parse_result_t res_q;

	assign can_load = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load)
			res_q <= res;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = res_q.value;
	assign m_axis_tuser  = {res_q.was_decimal, res_q.ok};

endmodule

// ===== hw/rtl/pnp_checker.sv =====
`include "assert_macros.svh"

module pnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// reset clears the output stage asynchronously, so no result follows reset low
	`PNP_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |=> !m_axis_tvalid)

	// a failed parse always reports a zero value
	`PNP_ASSERT(a_fail_zero, clk, arst_n,
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0))

	// an empty output stage registers a final character in s1, then its result
	`PNP_ASSERT(a_result_from_last, clk, arst_n,
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))

	`PNP_ASSERT(a_out_hold, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

endmodule

bind prefixed_number_text_parser pnp_checker u_pnp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== test/number_text_checker.sv =====
module number_text_checker import pnp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	output int          mismatch_count,
	output int          results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] INT32_TOP = 64'h0000_0000_7FFF_FFFF;

	// shadow of the parse state and the mode register
	phase_t      ph;
	logic [7:0]  held;
	logic        in_dec;
	logic [63:0] acc;
	logic        saw_bad;
	logic        saw_ovf;
	logic        saw_digit;
	logic        width32;

	parse_result_t expected_numbers[$];
	int            errs;

	function automatic void restart_text();
		ph        = PH_START;
		held      = 8'd0;
		in_dec    = 1'b0;
		acc       = 64'd0;
		saw_bad   = 1'b0;
		saw_ovf   = 1'b0;
		saw_digit = 1'b0;
	endfunction

	function automatic int radix_digit(input logic [7:0] c, input logic dec);
		if (c >= "0" && c <= "9")
			return int'(c) - int'(CH_ZERO);
		if (!dec && c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (!dec && c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void feed_body(input logic [7:0] c);
		int d;
		if (c == CH_TICK)
			return;
		d = radix_digit(c, in_dec);
		if (d < 0) begin
			saw_bad = 1'b1;
			return;
		end
		saw_digit = 1'b1;
		// once overflowed the accumulator is frozen
		if (saw_ovf)
			return;
		if (in_dec) begin
			if (acc > (ALL_ONES - 64'(d)) / 64'd10)
				saw_ovf = 1'b1;
			else
				acc = acc * 64'd10 + 64'(d);
		end else if (acc[63:60] != 4'd0) begin
			saw_ovf = 1'b1;
		end else begin
			acc = {acc[59:0], 4'(d)};
		end
	endfunction

	// returns 1 when the character closes a text and res holds its number
	function automatic bit take_char(input logic [7:0] c, input logic fin,
		output parse_result_t res);
		logic        is_x;
		logic        is_n;
		logic        good;
		logic [63:0] num;
		is_x = (c == CH_LO_X) || (c == CH_UP_X);
		is_n = (c == CH_LO_N) || (c == CH_UP_N);
		res  = '0;
		case (ph)
			PH_START: begin
				if (is_x || is_n) begin
					in_dec = is_n;
					ph     = PH_BODY;
				end else if ((c == CH_ZERO || c == CH_BSLASH) && !fin) begin
					held = c;
					ph   = PH_HELD;
				end else begin
					ph = PH_BODY;
					feed_body(c);
				end
			end
			PH_HELD: begin
				ph = PH_BODY;
				if (is_x || is_n) begin
					in_dec = is_n;
				end else begin
					feed_body(held);
					feed_body(c);
				end
			end
			default: feed_body(c);
		endcase
		if (!fin)
			return 1'b0;
		good = !saw_bad && saw_digit;
		num  = acc;
		if (!width32) begin
			// 64-bit: decimal overflow fails, hex overflow saturates
			if (saw_ovf) begin
				if (in_dec)
					good = 1'b0;
				else
					num = ALL_ONES;
			end
		end else if (saw_ovf || acc > INT32_TOP) begin
			good = 1'b0;
		end
		res.ok          = good;
		res.value       = good ? num : 64'd0;
		res.was_decimal = in_dec;
		restart_text();
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		if (!arst_n) begin
			restart_text();
			width32 = 1'b0;
			expected_numbers.delete();
			errs = 0;
			mismatch_count <= 0;
			results_owed   <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				width32 = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_numbers.size() == 0) begin
					$error("result beat with no text pending: value %h user %b",
						m_axis_tdata, m_axis_tuser);
					errs++;
				end else begin
					want = expected_numbers.pop_front();
					if (m_axis_tuser[0] !== want.ok) begin
						$error("ok: expected %b, got %b", want.ok, m_axis_tuser[0]);
						errs++;
					end
					if (m_axis_tdata !== want.value) begin
						$error("value: expected %h, got %h", want.value, m_axis_tdata);
						errs++;
					end
					if (m_axis_tuser[1] !== want.was_decimal) begin
						$error("was_decimal: expected %b, got %b", want.was_decimal,
							m_axis_tuser[1]);
						errs++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (take_char(s_axis_tdata, s_axis_tlast, want))
					expected_numbers.insert(expected_numbers.size(), want);
			end
			mismatch_count <= errs;
			results_owed   <= expected_numbers.size();
		end
	end

endmodule

// ===== test/tb_prefixed_number_text_parser.sv =====
module tb_prefixed_number_text_parser import pnp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_CHARS = 1300;
	localparam int QUIET_LIMIT  = 2000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_data      = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tready = 1'b0;
	logic        cfg_ready;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	int          mismatch_count;
	int          results_owed;
	int          quiet_cycles = 0;
	bit          tx_calm      = 1'b0;
	logic [7:0]  line_buf[$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	prefixed_number_text_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	number_text_checker i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void push_digit(input int d);
		if (d < 10)
			line_buf.insert(line_buf.size(), 8'(int'(CH_ZERO) + d));
		else
			line_buf.insert(line_buf.size(),
				8'(($urandom_range(0, 1) ? int'("A") : int'("a")) + d - 10));
		if ($urandom_range(0, 11) == 0)
			line_buf.insert(line_buf.size(), CH_TICK);
	endfunction

	function automatic void push_number(input logic [63:0] val, input logic dec);
		int          digits[$];
		logic [63:0] v;
		v = val;
		if ($urandom_range(0, 3) == 0)
			push_digit(0);
		do begin
			if (dec) begin
				digits.push_front(int'(v % 64'd10));
				v = v / 64'd10;
			end else begin
				digits.push_front(int'(v[3:0]));
				v = v >> 4;
			end
		end while (v != 64'd0);
		foreach (digits[i])
			push_digit(digits[i]);
	endfunction

	function automatic void make_text();
		int          form;
		int          pfx;
		int          style;
		logic        dec;
		logic [63:0] val;
		logic [7:0]  bad;
		line_buf.delete();
		form = $urandom_range(0, 99);
		if (form >= 90) begin
			repeat ($urandom_range(1, 6))
				line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
			return;
		end
		// 0: no prefix (hex), 1..6 hex prefixes, 7..12 decimal prefixes
		pfx = $urandom_range(0, 12);
		dec = (pfx >= 7);
		if (pfx != 0) begin
			style = (pfx - 1) % 6;
			if (style < 2)
				line_buf.insert(line_buf.size(), CH_ZERO);
			else if (style < 4)
				line_buf.insert(line_buf.size(), CH_BSLASH);
			if (dec)
				line_buf.insert(line_buf.size(), (style % 2) ? CH_UP_N : CH_LO_N);
			else
				line_buf.insert(line_buf.size(), (style % 2) ? CH_UP_X : CH_LO_X);
		end
		if (form < 72) begin
			case ($urandom_range(0, 4))
				0: val = 64'($urandom_range(0, 4095));
				1: val = 64'($urandom);
				2: val = {32'($urandom), 32'($urandom)};
				default: begin
					// overflow boundaries of both widths, nudged by one either way
					case ($urandom_range(0, 5))
						0: val = 64'h0000_0000_7FFF_FFFF;
						1: val = 64'h0000_0000_8000_0000;
						2: val = ALL_ONES;
						3: val = 64'h1999_9999_9999_9999;
						4: val = 64'h0FFF_FFFF_FFFF_FFFF;
						default: val = 64'h1000_0000_0000_0000;
					endcase
					val = val + 64'($urandom_range(0, 2)) - 64'd1;
				end
			endcase
			push_number(val, dec);
			if ($urandom_range(0, 2) == 0)
				push_digit($urandom_range(0, dec ? 9 : 15));
		end else if (form < 80) begin
			repeat ($urandom_range(0, 2))
				line_buf.insert(line_buf.size(), CH_TICK);
		end else begin
			push_number(64'($urandom_range(0, 65535)), dec);
			case ($urandom_range(0, 3))
				0: bad = "g";
				1: bad = 8'($urandom_range(128, 255));
				2: bad = dec ? 8'(int'("a") + $urandom_range(0, 5)) : "-";
				default: bad = 8'($urandom_range(0, 47));
			endcase
			line_buf.insert($urandom_range(0, line_buf.size()), bad);
		end
		if (line_buf.size() == 0)
			line_buf.insert(line_buf.size(), CH_TICK);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_char(line_buf[i], i == line_buf.size() - 1);
	endtask

	task automatic send_str(input string s);
		line_buf.delete();
		for (int i = 0; i < s.len(); i++)
			line_buf.insert(line_buf.size(), s[i]);
		send_line();
	endtask

	// hold the sender until every pending number has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_width_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent;
		int phase_end;
		int round;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_width_mode(1'b0);
		send_str("0");
		send_str("\\");
		send_str("X");
		send_str("n");
		line_buf = '{8'h00};
		send_line();
		line_buf = '{8'hFF};
		send_line();
		line_buf = '{CH_TICK};
		send_line();
		send_str("0x");
		send_str("\\N9");
		line_buf = '{CH_ZERO, CH_TICK};
		send_line();
		send_str("Fa");
		send_str("\\X");
		send_str("0N");
		send_str("\\g");
		drain_results();

		sent  = 0;
		round = 0;
		while (sent < RANDOM_CHARS) begin
			if (round < 2)
				set_width_mode(round == 0);
			else
				set_width_mode($urandom_range(0, 1));
			phase_end = sent + $urandom_range(150, 300);
			while (sent < phase_end && sent < RANDOM_CHARS) begin
				make_text();
				tx_calm = ($urandom_range(0, 7) == 0);
				sent += line_buf.size();
				send_line();
			end
			drain_results();
			round++;
		end

		if (mismatch_count == 0 && results_owed == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		int hold;
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 5) == 0) begin
				hold  = $urandom_range(30, 80);
				stall = 0;
			end else begin
				hold  = $urandom_range(1, 12);
				stall = pick_gap(1'b0);
			end
			m_axis_tready <= 1'b1;
			repeat (hold) @(posedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
			|| (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
